### src/tbe_pkg.sv
// Shared constants, types and codes of the trace baseline estimator.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package tbe_pkg;

	localparam int unsigned MAX_SAMPLES   = 4096;
	localparam int unsigned SAMPLE_BITS   = 12;
	localparam int unsigned FRACTION_BITS = 8;

	localparam int unsigned THR_W      = 12;
	localparam int unsigned MINP_W     = 13;
	localparam int unsigned CFG_DATA_W = (THR_W > MINP_W) ? THR_W : MINP_W;

	// Sample counter holds MAX_SAMPLES itself; a tested index stays below it.
	localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned IDX_W  = $clog2(MAX_SAMPLES);
	localparam int unsigned SUM_W  = SAMPLE_BITS + IDX_W;
	localparam int unsigned PTHR_W = THR_W + IDX_W;
	localparam int unsigned CMP_W  = (SUM_W > PTHR_W) ? SUM_W : PTHR_W;
	localparam int unsigned NB_W   = (SAMPLE_BITS > THR_W + 1) ? SAMPLE_BITS : THR_W + 1;
	localparam int unsigned LEN_W  = (CNT_W > MINP_W) ? CNT_W : MINP_W;
	localparam int unsigned BASE_W = SAMPLE_BITS + FRACTION_BITS;
	localparam int unsigned DIVD_W = SUM_W + FRACTION_BITS;
	localparam int unsigned STEP_W = $clog2(DIVD_W);

	typedef enum logic [1:0] {
		ST_VALID = 2'd0,
		ST_FEW   = 2'd1,
		ST_SHORT = 2'd2
	} status_t;

	typedef enum logic {
		REG_THRESHOLD  = 1'b0,
		REG_MIN_POINTS = 1'b1
	} cfg_reg_t;

	// One finished trace, handed from the front to the back.
	typedef struct packed {
		status_t            status;
		logic [SUM_W-1:0]   sum;
		logic [CNT_W-1:0]   count;
	} job_t;

endpackage

`default_nettype wire

### src/tbe_sample_if.sv
// Input channel of the estimator: one ADC sample word with its last flag.
// Depends on tbe_pkg for the sample width.
`default_nettype none

interface tbe_sample_if;
	logic                            valid;
	logic                            ready;
	logic [tbe_pkg::SAMPLE_BITS-1:0] sample;
	logic                            last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

`default_nettype wire

### src/tbe_result_if.sv
// Output channel of the estimator: one report word per trace.
// Depends on tbe_pkg for the status type and field widths.
`default_nettype none

interface tbe_result_if;
	logic                       valid;
	logic                       ready;
	tbe_pkg::status_t           status;
	logic [tbe_pkg::BASE_W-1:0] baseline;
	logic [tbe_pkg::CNT_W-1:0]  points_used;

	modport source (output valid, output status, output baseline, output points_used,
		input ready);
	modport sink   (input valid, input status, input baseline, input points_used,
		output ready);
endinterface

`default_nettype wire

### src/tbe_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on tbe_pkg for the register codes and data width.
`default_nettype none

interface tbe_cfg_if;
	logic                           valid;
	logic                           ready;
	tbe_pkg::cfg_reg_t              index;
	logic [tbe_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/tbe_front.sv
// Front part: accepts samples, keeps the running statistics of the trace and
// classifies it at its last sample. Depends on tbe_pkg and the sample and config interfaces.
`default_nettype none

module tbe_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	tbe_sample_if.sink         samples,
	tbe_cfg_if.sink            cfg,
	input  wire logic          job_full,
	output logic               job_push,
	output tbe_pkg::job_t      job
);

	logic [tbe_pkg::THR_W-1:0]       threshold_q;
	logic [tbe_pkg::MINP_W-1:0]      min_points_q;
	logic [tbe_pkg::CNT_W-1:0]       count_q;
	logic [tbe_pkg::SUM_W-1:0]       sum_q;
	logic [tbe_pkg::CNT_W-1:0]       avg_q;
	logic [tbe_pkg::SAMPLE_BITS-1:0] prev_q;
	logic                            stopped_q;
	logic [tbe_pkg::CNT_W-1:0]       stop_pos_q;

	logic                            accept;
	logic                            in_range;
	logic                            test;
	logic                            fail;
	logic [tbe_pkg::IDX_W-1:0]       n;
	logic [tbe_pkg::SUM_W-1:0]       sum_add;
	logic [tbe_pkg::SUM_W-1:0]       prod_x;
	logic [tbe_pkg::PTHR_W-1:0]      prod_t;
	logic [tbe_pkg::SUM_W-1:0]       diff_mean;
	logic [tbe_pkg::SAMPLE_BITS-1:0] diff_prev;
	logic [tbe_pkg::CNT_W-1:0]       count_nx;
	logic [tbe_pkg::SUM_W-1:0]       sum_nx;
	logic [tbe_pkg::CNT_W-1:0]       avg_nx;
	logic                            stopped_nx;
	logic [tbe_pkg::CNT_W-1:0]       stop_pos_nx;
	logic [tbe_pkg::CNT_W-1:0]       reach;

	assign cfg.ready     = 1'b1;
	assign samples.ready = !job_full;
	assign accept        = samples.valid && !job_full;

	assign in_range = count_q < tbe_pkg::CNT_W'(tbe_pkg::MAX_SAMPLES);
	assign n        = count_q[tbe_pkg::IDX_W-1:0];
	assign test     = in_range && (n != '0) && !stopped_q;
	assign sum_add  = sum_q + tbe_pkg::SUM_W'(prev_q);
	assign prod_x   = tbe_pkg::SUM_W'(samples.sample) * tbe_pkg::SUM_W'(n);
	assign prod_t   = tbe_pkg::PTHR_W'(threshold_q) * tbe_pkg::PTHR_W'(n);

	always_comb begin
		if (prod_x >= sum_add) begin
			diff_mean = prod_x - sum_add;
		end else begin
			diff_mean = sum_add - prod_x;
		end
		if (samples.sample >= prev_q) begin
			diff_prev = samples.sample - prev_q;
		end else begin
			diff_prev = prev_q - samples.sample;
		end
	end

	// The mean test compares scaled by n, so no division is needed per sample.
	assign fail = (tbe_pkg::CMP_W'(diff_mean) > tbe_pkg::CMP_W'(prod_t)) ||
		(tbe_pkg::NB_W'(diff_prev) > tbe_pkg::NB_W'({threshold_q, 1'b0}));

	assign count_nx    = in_range ? count_q + 1'b1 : count_q;
	assign sum_nx      = test ? sum_add : sum_q;
	assign avg_nx      = test ? tbe_pkg::CNT_W'(n) : avg_q;
	assign stopped_nx  = stopped_q || (test && fail);
	assign stop_pos_nx = (test && fail) ? tbe_pkg::CNT_W'(n) : stop_pos_q;
	assign reach       = stopped_nx ? stop_pos_nx : count_nx;

	always_comb begin
		job.sum = sum_nx;
		if (tbe_pkg::LEN_W'(count_nx) < tbe_pkg::LEN_W'(min_points_q)) begin
			job.status = tbe_pkg::ST_SHORT;
			job.count  = '0;
		end else if ((tbe_pkg::LEN_W'(reach) >= tbe_pkg::LEN_W'(min_points_q)) &&
			(avg_nx != '0)) begin
			job.status = tbe_pkg::ST_VALID;
			job.count  = avg_nx;
		end else begin
			job.status = tbe_pkg::ST_FEW;
			job.count  = avg_nx;
		end
	end

	assign job_push = accept && samples.last_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= tbe_pkg::THR_W'(10);
			min_points_q <= tbe_pkg::MINP_W'(50);
		end else if (cfg.valid) begin
			case (cfg.index)
				tbe_pkg::REG_THRESHOLD:  threshold_q  <= cfg.data[tbe_pkg::THR_W-1:0];
				tbe_pkg::REG_MIN_POINTS: min_points_q <= cfg.data[tbe_pkg::MINP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			sum_q      <= '0;
			avg_q      <= '0;
			prev_q     <= '0;
			stopped_q  <= 1'b0;
			stop_pos_q <= '0;
		end else if (accept) begin
			prev_q     <= in_range ? samples.sample : prev_q;
			stop_pos_q <= stop_pos_nx;
			if (samples.last_sample) begin
				count_q   <= '0;
				sum_q     <= '0;
				avg_q     <= '0;
				stopped_q <= 1'b0;
			end else begin
				count_q   <= count_nx;
				sum_q     <= sum_nx;
				avg_q     <= avg_nx;
				stopped_q <= stopped_nx;
			end
		end
	end

endmodule

`default_nettype wire

### src/tbe_queue.sv
// Two-entry queue of finished traces between front and back.
// Depends on tbe_pkg for the job type.
`default_nettype none

module tbe_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire tbe_pkg::job_t push_job,
	output logic               full,
	input  wire logic          pop,
	output logic               nonempty,
	output tbe_pkg::job_t      pop_job
);

	tbe_pkg::job_t entry_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    fill_q;

	assign full     = fill_q == 2'd2;
	assign nonempty = fill_q != 2'd0;
	assign pop_job  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

### src/tbe_back.sv
// Back part: takes finished traces from the queue, for a valid one divides sum by count
// one quotient bit per cycle and holds the report word. Depends on tbe_pkg, tbe_result_if.
`default_nettype none

module tbe_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	input  wire tbe_pkg::job_t job,
	output logic               job_pop,
	tbe_result_if.source       results
);

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIVIDE,
		B_SHOW
	} back_state_t;

	back_state_t                  state_q;
	logic [tbe_pkg::DIVD_W-1:0]   dividend_q;
	logic [tbe_pkg::CNT_W-1:0]    divisor_q;
	logic [tbe_pkg::CNT_W-1:0]    rem_q;
	logic [tbe_pkg::STEP_W-1:0]   step_q;
	tbe_pkg::status_t             status_q;
	logic [tbe_pkg::BASE_W-1:0]   baseline_q;
	logic [tbe_pkg::CNT_W-1:0]    used_q;

	logic [tbe_pkg::CNT_W:0]      rem_shift;
	logic                         qbit;
	logic [tbe_pkg::CNT_W:0]      rem_sub;
	logic [tbe_pkg::DIVD_W-1:0]   dividend_nx;

	assign job_pop = (state_q == B_IDLE) && job_valid;

	// Restoring division: the quotient shifts in where the dividend shifts out.
	assign rem_shift   = {rem_q, dividend_q[tbe_pkg::DIVD_W-1]};
	assign qbit        = rem_shift >= {1'b0, divisor_q};
	assign rem_sub     = rem_shift - {1'b0, divisor_q};
	assign dividend_nx = {dividend_q[tbe_pkg::DIVD_W-2:0], qbit};

	assign results.valid       = state_q == B_SHOW;
	assign results.status      = status_q;
	assign results.baseline    = baseline_q;
	assign results.points_used = used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			dividend_q <= '0;
			divisor_q  <= '0;
			rem_q      <= '0;
			step_q     <= '0;
			status_q   <= tbe_pkg::ST_VALID;
			baseline_q <= '0;
			used_q     <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						status_q   <= job.status;
						used_q     <= job.count;
						baseline_q <= '0;
						dividend_q <= {job.sum, {tbe_pkg::FRACTION_BITS{1'b0}}};
						divisor_q  <= job.count;
						rem_q      <= '0;
						step_q     <= '0;
						if (job.status == tbe_pkg::ST_VALID) begin
							state_q <= B_DIVIDE;
						end else begin
							state_q <= B_SHOW;
						end
					end
				end
				B_DIVIDE: begin
					dividend_q <= dividend_nx;
					rem_q      <= qbit ? rem_sub[tbe_pkg::CNT_W-1:0]
						: rem_shift[tbe_pkg::CNT_W-1:0];
					step_q     <= step_q + 1'b1;
					if (step_q == tbe_pkg::STEP_W'(tbe_pkg::DIVD_W - 1)) begin
						baseline_q <= dividend_nx[tbe_pkg::BASE_W-1:0];
						state_q    <= B_SHOW;
					end
				end
				B_SHOW: begin
					if (results.ready) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### src/trace_baseline_estimator_core.sv
// Trace baseline estimator, top level. Samples are taken one per cycle while the queue
// has room; the report word of a trace passes the trace queue and, for a valid trace,
// the divider (one quotient bit per cycle over the 32-bit scaled sum) before it is held.
// A two-entry trace queue lets the sample side run on while the divider works;
// samples stall only when two finished traces wait. Reset (arst_n low, async)
// clears all trace state and sets threshold to 10 and min_points to 50.
`default_nettype none

module trace_baseline_estimator_core (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tbe_sample_if.sink   samples,
	tbe_result_if.source results,
	tbe_cfg_if.sink      cfg
);

	// The front part does all per-sample work as each sample is accepted: it adds the previous
	// sample into the running sum, tests the new sample against the mean (scaled
	// by the count, so no division is needed) and against its neighbor, and on
	// the last word of a trace classifies it and hands a job to the queue.
	logic          job_push;
	logic          queue_full;
	logic          queue_nonempty;
	logic          job_pop;
	tbe_pkg::job_t push_job;
	tbe_pkg::job_t pop_job;

	tbe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples),
		.cfg      (cfg),
		.job_full (queue_full),
		.job_push (job_push),
		.job      (push_job)
	);

	// The queue decouples both sides so that a slow result sink or a long
	// division does not hold up sample intake until the queue fills.
	tbe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (push_job),
		.full     (queue_full),
		.pop      (job_pop),
		.nonempty (queue_nonempty),
		.pop_job  (pop_job)
	);

	// The back part turns a valid job into a baseline with a bit-serial divider
	// and holds the report word in its output registers until it is taken.
	tbe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (queue_nonempty),
		.job       (pop_job),
		.job_pop   (job_pop),
		.results   (results)
	);

`ifndef SYNTH
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !queue_full)
		else $error("trace queue written while full");

	a_baseline_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.status != tbe_pkg::ST_VALID) |-> results.baseline == '0)
		else $error("baseline set on a report that is not valid");

	a_short_uses_none: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.status == tbe_pkg::ST_SHORT) |-> results.points_used == '0)
		else $error("short trace reports averaged points");

	a_valid_has_points: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.status == tbe_pkg::ST_VALID) |-> results.points_used != '0)
		else $error("valid baseline with no averaged points");
`endif

endmodule

`default_nettype wire
